### rtl/ali_pkg.sv
// Shared types and constants of the arc length interpolator.
// Holds the input and result word structs and the CORDIC angle table.
// No dependencies.
`timescale 1ns / 1ps

package ali_pkg;

  // Width of a coordinate difference, and of its magnitude
  localparam int DW = 33;
  // Width of a sum of two squared differences
  localparam int SQW = 2 * DW;
  // Width of the query and of the travelled arc length
  localparam int QW = 40;
  localparam int CORDIC_STEPS = 20;

  localparam logic [1:0] KIND_INTERP = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_END    = 2'd2;

  localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518
  };

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [15:0] point_heading;
    logic signed [31:0] point_speed;
    logic               last_point;
  } ali_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [15:0] out_heading;
    logic signed [31:0] out_speed;
    logic        [1:0]  out_kind;
  } ali_out_t;

endpackage

### rtl/ali_atan2.sv
// Iterative atan2 of a segment direction: normalize one bit a cycle,
// then a quadrant pre-rotation and 20 CORDIC vectoring steps, one per cycle.
// Depends on ali_pkg for the angle table.
`timescale 1ns / 1ps

module ali_atan2 (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [ali_pkg::DW-1:0]    dx,
  input  logic signed [ali_pkg::DW-1:0]    dy,
  output logic                             done,
  output logic signed [15:0]               heading
);

  localparam int XW = ali_pkg::DW + 4;

  typedef enum logic [1:0] {A_IDLE, A_NORM, A_ROT, A_STEP} astate_t;

  astate_t              state_r;
  logic signed [XW-1:0] x_r, y_r;
  logic [31:0]          ang_r;
  logic [4:0]           i_r;
  logic                 done_r;

  logic signed [XW-1:0] ax, ay, xs, ys;
  logic                 mag_low, y_pos;
  logic [31:0]          hsum;

  always_comb begin
    ax      = x_r[XW-1] ? -x_r : x_r;
    ay      = y_r[XW-1] ? -y_r : y_r;
    mag_low = (ax[XW-1:32] == '0) && (ay[XW-1:32] == '0);
    xs      = x_r >>> i_r;
    ys      = y_r >>> i_r;
    y_pos   = !y_r[XW-1] && (y_r != '0);
    hsum    = ang_r + 32'h0000_8000;
  end

  assign done    = done_r;
  assign heading = hsum[31:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      case (state_r)
        A_IDLE: begin
          if (start) begin
            x_r   <= {{(XW-ali_pkg::DW){dx[ali_pkg::DW-1]}}, dx};
            y_r   <= {{(XW-ali_pkg::DW){dy[ali_pkg::DW-1]}}, dy};
            ang_r <= '0;
            if (dx == '0 && dy == '0) begin
              done_r <= 1'b1;
            end else begin
              done_r  <= 1'b0;
              state_r <= A_NORM;
            end
          end
        end
        A_NORM: begin
          // double both until the larger magnitude reaches 2^32
          if (mag_low) begin
            x_r <= x_r <<< 1;
            y_r <= y_r <<< 1;
          end else begin
            state_r <= A_ROT;
          end
        end
        A_ROT: begin
          if (x_r[XW-1]) begin
            if (!y_r[XW-1]) begin
              x_r   <= y_r;
              y_r   <= -x_r;
              ang_r <= 32'h4000_0000;
            end else begin
              x_r   <= -y_r;
              y_r   <= x_r;
              ang_r <= 32'hC000_0000;
            end
          end
          i_r     <= '0;
          state_r <= A_STEP;
        end
        A_STEP: begin
          if (y_pos) begin
            x_r   <= x_r + ys;
            y_r   <= y_r - xs;
            ang_r <= ang_r + ali_pkg::ATAN_TAB[i_r];
          end else begin
            x_r   <= x_r - ys;
            y_r   <= y_r + xs;
            ang_r <= ang_r - ali_pkg::ATAN_TAB[i_r];
          end
          if (i_r == 5'(ali_pkg::CORDIC_STEPS - 1)) begin
            done_r  <= 1'b1;
            state_r <= A_IDLE;
          end else begin
            i_r <= i_r + 5'd1;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

endmodule

### rtl/arc_length_interpolator_unit.sv
// Arc length interpolator over a streamed polyline, top level.
// Bit-serial squares, square root, division and interpolation products.
// Depends on ali_pkg and ali_atan2.
//
// Usage: write the query distance (unsigned, FRAC_BITS fraction bits) on
// the cfg_ channel while the block is idle; cfg_ready is always high.
// Then stream trajectory points on the in_ channel, one word per point,
// the final point marked by last_point. At most one result word per point
// leaves on the out_ channel: the start point, the end point, or the point
// interpolated along the first segment that reaches the query distance.
// Points after a hit are dropped until the last mark.
// A point that closes no segment is only evaluated or emitted. A segment
// point forms the sum of squares (one multiplier bit a cycle) and the
// square root (one root bit a cycle) and decides. A hit adds the division
// and the multiply, overlapped with the atan2 unit (normalize, then CORDIC).
// Reset clears the state, the phase, the query, the travelled length and
// the output valid flag. A result held by a stalled receiver keeps the
// next point's result waiting in the block; the next point is accepted
// meanwhile.
`timescale 1ns / 1ps

module arc_length_interpolator_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [ali_pkg::QW-1:0]  cfg_query_distance,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ali_pkg::ali_in_t        in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output ali_pkg::ali_out_t       out_data
);

  localparam int DW  = ali_pkg::DW;
  localparam int QW  = ali_pkg::QW;
  localparam int SQW = ali_pkg::SQW;
  localparam int TW  = FRAC_BITS + 1;
  localparam int PW  = DW + TW;
  localparam int STEPS_MAX = (TW > DW) ? TW : DW;
  localparam int CNT_W = $clog2(STEPS_MAX + 1);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SEARCH = 2'd1,
    PH_SKIP   = 2'd2
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_EVAL, S_SQ, S_SQRT, S_DECIDE, S_DIV, S_MUL, S_WAIT, S_EMIT
  } state_t;

  state_t                 state_r;
  phase_t                 phase_r;
  ali_pkg::ali_in_t       cur_r;
  logic signed [31:0]     px_r, py_r, pv_r;
  logic [QW-1:0]          trav_r, query_r;
  logic signed [DW-1:0]   dx_r, dy_r, dv_r;
  logic [DW-1:0]          ax_r, ay_r, mx_r, my_r;
  logic [SQW-1:0]         sq_r, rad_r;
  logic [DW+1:0]          rem_r;
  logic [DW-1:0]          root_r, part_r;
  logic [TW-1:0]          q_r;
  logic signed [PW-1:0]   accx_r, accy_r, accv_r;
  logic [CNT_W-1:0]       cnt_r;
  ali_pkg::ali_out_t      res_r, out_r;
  logic                   out_valid_r;

  // combinational helpers
  logic signed [DW-1:0]   ddx, ddy, ddv, adx, ady;
  logic [SQW-1:0]         sq_nxt;
  logic [DW+3:0]          rem_sh, trial;
  logic                   sq_ge;
  logic [QW:0]            reach;
  logic                   hit;
  logic [QW-1:0]          diff, trav_nxt;
  logic [DW-1:0]          remv;
  logic                   ge0;
  logic [DW:0]            dsh;
  logic                   dge;
  logic                   tb;
  logic                   atan_start, atan_done;
  logic signed [15:0]     atan_heading;
  logic                   slot_free;

  always_comb begin
    ddx = {cur_r.point_x[31], cur_r.point_x} - {px_r[31], px_r};
    ddy = {cur_r.point_y[31], cur_r.point_y} - {py_r[31], py_r};
    ddv = {cur_r.point_speed[31], cur_r.point_speed} - {pv_r[31], pv_r};
    adx = ddx[DW-1] ? -ddx : ddx;
    ady = ddy[DW-1] ? -ddy : ddy;

    sq_nxt = {sq_r[SQW-2:0], 1'b0}
           + (mx_r[DW-1] ? SQW'(ax_r) : '0)
           + (my_r[DW-1] ? SQW'(ay_r) : '0);

    rem_sh = {rem_r, rad_r[SQW-1:SQW-2]};
    trial  = {2'b00, root_r, 2'b01};
    sq_ge  = rem_sh >= trial;

    reach    = {1'b0, trav_r} + (QW+1)'(root_r);
    hit      = reach >= {1'b0, query_r};
    diff     = (query_r > trav_r) ? (query_r - trav_r) : '0;
    remv     = (diff > QW'(root_r)) ? root_r : diff[DW-1:0];
    ge0      = remv >= root_r;
    trav_nxt = reach[QW] ? {QW{1'b1}} : reach[QW-1:0];

    dsh = {part_r, 1'b0};
    dge = dsh >= {1'b0, root_r};
    tb  = q_r[TW-1];

    atan_start = (state_r == S_DECIDE) && hit;
    slot_free  = !out_valid_r || out_ready;
  end

  ali_atan2 u_atan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (atan_start),
    .dx      (dx_r),
    .dy      (dy_r),
    .done    (atan_done),
    .heading (atan_heading)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FIRST;
      query_r     <= '0;
      trav_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        query_r <= cfg_query_distance;
      end
      // a load in S_EMIT takes over the handoff of the old word
      if (out_valid_r && out_ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cur_r   <= in_data;
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_r <= '{out_x: cur_r.point_x, out_y: cur_r.point_y,
                     out_heading: cur_r.point_heading,
                     out_speed: cur_r.point_speed,
                     out_kind: (query_r == '0) ? ali_pkg::KIND_START
                                               : ali_pkg::KIND_END};
          case (phase_r)
            PH_FIRST: begin
              px_r   <= cur_r.point_x;
              py_r   <= cur_r.point_y;
              pv_r   <= cur_r.point_speed;
              trav_r <= '0;
              if (query_r == '0) begin
                phase_r <= cur_r.last_point ? PH_FIRST : PH_SKIP;
                state_r <= S_EMIT;
              end else if (cur_r.last_point) begin
                state_r <= S_EMIT;
              end else begin
                phase_r <= PH_SEARCH;
                state_r <= S_IDLE;
              end
            end
            PH_SEARCH: begin
              dx_r    <= ddx;
              dy_r    <= ddy;
              dv_r    <= ddv;
              ax_r    <= adx;
              ay_r    <= ady;
              mx_r    <= adx;
              my_r    <= ady;
              sq_r    <= '0;
              cnt_r   <= '0;
              state_r <= S_SQ;
            end
            default: begin
              // skipping to the last mark; drop the point
              if (cur_r.last_point) begin
                phase_r <= PH_FIRST;
              end
              state_r <= S_IDLE;
            end
          endcase
        end
        S_SQ: begin
          sq_r <= sq_nxt;
          mx_r <= {mx_r[DW-2:0], 1'b0};
          my_r <= {my_r[DW-2:0], 1'b0};
          if (cnt_r == CNT_W'(DW - 1)) begin
            rad_r   <= sq_nxt;
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_SQRT: begin
          rad_r  <= {rad_r[SQW-3:0], 2'b00};
          rem_r  <= sq_ge ? (DW+2)'(rem_sh - trial) : rem_sh[DW+1:0];
          root_r <= {root_r[DW-2:0], sq_ge};
          if (cnt_r == CNT_W'(DW - 1)) begin
            state_r <= S_DECIDE;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_DECIDE: begin
          cnt_r  <= '0;
          accx_r <= '0;
          accy_r <= '0;
          accv_r <= '0;
          if (hit) begin
            phase_r <= cur_r.last_point ? PH_FIRST : PH_SKIP;
            if (root_r == '0) begin
              q_r     <= '0;
              state_r <= S_MUL;
            end else begin
              q_r     <= TW'(ge0);
              part_r  <= ge0 ? (remv - root_r) : remv;
              state_r <= S_DIV;
            end
          end else begin
            trav_r <= trav_nxt;
            px_r   <= cur_r.point_x;
            py_r   <= cur_r.point_y;
            pv_r   <= cur_r.point_speed;
            if (cur_r.last_point) begin
              phase_r <= PH_FIRST;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_DIV: begin
          part_r <= dge ? DW'(dsh - {1'b0, root_r}) : dsh[DW-1:0];
          q_r    <= {q_r[TW-2:0], dge};
          if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
            cnt_r   <= '0;
            state_r <= S_MUL;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_MUL: begin
          // most significant bit of t first: shift, then add the delta
          accx_r <= (accx_r <<< 1) + (tb ? PW'(dx_r) : PW'(0));
          accy_r <= (accy_r <<< 1) + (tb ? PW'(dy_r) : PW'(0));
          accv_r <= (accv_r <<< 1) + (tb ? PW'(dv_r) : PW'(0));
          q_r    <= {q_r[TW-2:0], 1'b0};
          if (cnt_r == CNT_W'(TW - 1)) begin
            state_r <= S_WAIT;
          end else begin
            cnt_r <= cnt_r + CNT_W'(1);
          end
        end
        S_WAIT: begin
          if (atan_done) begin
            res_r.out_x       <= px_r + 32'(accx_r >>> FRAC_BITS);
            res_r.out_y       <= py_r + 32'(accy_r >>> FRAC_BITS);
            res_r.out_speed   <= pv_r + 32'(accv_r >>> FRAC_BITS);
            res_r.out_heading <= atan_heading;
            res_r.out_kind    <= ali_pkg::KIND_INTERP;
            state_r           <= S_EMIT;
          end
        end
        S_EMIT: begin
          // hold until the output register frees
          if (slot_free) begin
            out_r       <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/ali_checker.sv
// Port-level checks for the arc length interpolator, and the bind that
// attaches them to arc_length_interpolator_unit.
// Depends on ali_pkg for the result word type.
`timescale 1ns / 1ps

module ali_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ali_pkg::ali_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed or dropped");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.out_kind == ali_pkg::KIND_INTERP ||
                   out_data.out_kind == ali_pkg::KIND_START ||
                   out_data.out_kind == ali_pkg::KIND_END))
    else $error("result word with unknown kind");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind arc_length_interpolator_unit ali_checker u_ali_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
